FILE: rtl/tswr_pkg.sv
package tswr_pkg;

   localparam logic [2:0] FUNC_STEP      = 3'd0;
   localparam logic [2:0] FUNC_SET_SCALE = 3'd1;
   localparam logic [2:0] FUNC_RESCALE   = 3'd2;
   localparam logic [2:0] FUNC_SET_CLOCK = 3'd3;
   localparam logic [2:0] FUNC_READ      = 3'd4;

   localparam logic REG_WRAP_THR     = 1'b0;
   localparam logic REG_MISORDER_THR = 1'b1;

   localparam logic [31:0] THR_RESET    = 32'h8000_0000;
   localparam logic [31:0] NATIVE_RESET = 32'd1;

   localparam int unsigned MUL_STEPS = 32;
   localparam int unsigned DIV_STEPS = 64;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   typedef enum logic [1:0] {
      ALU_MUL = 2'd0,
      ALU_DIV = 2'd1,
      ALU_ADD = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] ts_value;
      logic [31:0] src_wrap;
      logic [31:0] in_scale;
      logic [31:0] out_scale;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        accepted;
      logic        status;
   } rsp_payload_type;

   typedef struct packed {
      logic        start;
      alu_op_type  op;
      logic [63:0] opnd_a;
      logic [31:0] opnd_b;
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
      logic [31:0] rem;
   } alu_rsp_type;

endpackage

FILE: rtl/tswr_alu.sv
module tswr_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  tswr_pkg::alu_cmd_type cmd,
   output tswr_pkg::alu_rsp_type rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   tswr_pkg::alu_op_type       op_ff, op_in;
   logic [63:0]                acc_ff, acc_in;
   logic [63:0]                mcand_ff, mcand_in;
   logic [31:0]                opb_ff, opb_in;
   logic [31:0]                rem_ff, rem_in;
   logic [tswr_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [32:0] remsh;
   logic [63:0] add_a;
   logic [63:0] add_b;
   logic        cin;
   logic [64:0] sum;
   logic        fit;

   always_comb begin
      remsh = {rem_ff, acc_ff[63]};
      case (op_ff)
         tswr_pkg::ALU_MUL: begin
            add_a = {acc_ff[62:0], 1'b0};
            add_b = opb_ff[31] ? mcand_ff : 64'd0;
            cin   = 1'b0;
         end
         tswr_pkg::ALU_DIV: begin
            add_a = {31'd0, remsh};
            add_b = ~{32'd0, opb_ff};
            cin   = 1'b1;
         end
         default: begin
            add_a = acc_ff;
            add_b = {32'd0, opb_ff};
            cin   = 1'b0;
         end
      endcase
      sum = {1'b0, add_a} + {1'b0, add_b} + {64'd0, cin};
      fit = sum[64];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      opb_in   = opb_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (busy_ff) begin
         case (op_ff)
            tswr_pkg::ALU_MUL: begin
               acc_in = sum[63:0];
               opb_in = {opb_ff[30:0], 1'b0};
            end
            tswr_pkg::ALU_DIV: begin
               rem_in = fit ? sum[31:0] : remsh[31:0];
               acc_in = {acc_ff[62:0], fit};
            end
            default: begin
               acc_in = sum[63:0];
            end
         endcase
         cnt_in = cnt_ff - tswr_pkg::CNT_ONE;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         opb_in  = cmd.opnd_b;
         case (cmd.op)
            tswr_pkg::ALU_MUL: begin
               acc_in   = 64'd0;
               mcand_in = cmd.opnd_a;
               cnt_in   = tswr_pkg::MUL_LAST;
            end
            tswr_pkg::ALU_DIV: begin
               acc_in = cmd.opnd_a;
               rem_in = 32'd0;
               cnt_in = tswr_pkg::DIV_LAST;
            end
            default: begin
               acc_in = cmd.opnd_a;
               cnt_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      opb_ff   <= opb_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = acc_ff;
   assign rsp.rem   = rem_ff;

endmodule

FILE: rtl/timestamp_wrap_extend_rescale_top.sv
// Timestamp clock with a 32-bit stamp, a wrap count and a native timescale. One request is
// taken at a time; req_stall stays high until its beat has been handed to the result register,
// which can hold one finished beat while the next request is taken. Multiplies, divides and
// bias adds run on a single shared 64-bit add/subtract unit, a multiply by shift-add and a
// divide by restoring division, one quotient bit per cycle. A step with input scaling runs
// multiply, divide, multiply, divide; a step in native units multiply, divide; set-from-scale
// multiply, bias add, divide, divide; rescale and set-from-clock multiply, divide, divide;
// read-converted multiply, bias add, divide; a refused or unused operation runs none.
// Configuration registers: wrap limit at 0x0 and misorder limit at 0x4, both resetting to 0x80000000.
module timestamp_wrap_extend_rescale_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tswr_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tswr_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL1 = 8'b0000_0010,
      ST_BIAS = 8'b0000_0100,
      ST_DIV1 = 8'b0000_1000,
      ST_MUL2 = 8'b0001_0000,
      ST_DIV2 = 8'b0010_0000,
      ST_MOD  = 8'b0100_0000,
      ST_RESP = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tswr_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   tswr_pkg::rsp_payload_type res_ff, res_in;
   logic [31:0]               stamp_ff, stamp_in;
   logic [31:0]               wrap_ff, wrap_in;
   logic [31:0]               native_ff, native_in;
   logic [31:0]               wthr_ff, wthr_in;
   logic [31:0]               mthr_ff, mthr_in;
   logic [2:0]                func_ff, func_in;
   logic [31:0]               iscale_ff, iscale_in;
   logic [31:0]               oscale_ff, oscale_in;
   logic [31:0]               v_ff, v_in;
   logic [31:0]               qlo_ff, qlo_in;

   tswr_pkg::alu_cmd_type alu_cmd;
   tswr_pkg::alu_rsp_type alu_rsp;

   logic        csr_wr;
   logic        known;
   logic        err;
   logic [63:0] mul_a;
   logic [31:0] mul_b;
   logic [31:0] divisor1;
   logic [31:0] diff;
   logic [31:0] wrap_next;
   logic        take;

   tswr_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .rsp   (alu_rsp)
   );

   always_comb begin
      known = (req_data.func == tswr_pkg::FUNC_STEP) || (req_data.func == tswr_pkg::FUNC_SET_SCALE)
           || (req_data.func == tswr_pkg::FUNC_RESCALE)
           || (req_data.func == tswr_pkg::FUNC_SET_CLOCK)
           || (req_data.func == tswr_pkg::FUNC_READ);
      err = known && ((native_ff == 32'd0)
         || (((req_data.func == tswr_pkg::FUNC_SET_SCALE)
           || (req_data.func == tswr_pkg::FUNC_SET_CLOCK)) && (req_data.in_scale == 32'd0))
         || ((req_data.func == tswr_pkg::FUNC_RESCALE) && (req_data.out_scale == 32'd0)));
      case (req_data.func)
         tswr_pkg::FUNC_RESCALE: begin
            mul_a = {wrap_ff, stamp_ff};
            mul_b = req_data.out_scale;
         end
         tswr_pkg::FUNC_SET_CLOCK: begin
            mul_a = {req_data.src_wrap, req_data.ts_value};
            mul_b = native_ff;
         end
         tswr_pkg::FUNC_READ: begin
            mul_a = {32'd0, stamp_ff};
            mul_b = req_data.out_scale;
         end
         default: begin
            mul_a = {32'd0, req_data.ts_value};
            mul_b = native_ff;
         end
      endcase
      divisor1 = ((func_ff == tswr_pkg::FUNC_RESCALE) || (func_ff == tswr_pkg::FUNC_READ))
               ? native_ff : iscale_ff;
      diff      = v_ff - stamp_ff;
      wrap_next = wrap_ff + 32'd1;
      if (wrap_next >= native_ff) begin
         wrap_next = 32'd0;
      end
      take = (v_ff < stamp_ff) ? (diff < wthr_ff) : (diff < mthr_ff);
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      stamp_in     = stamp_ff;
      wrap_in      = wrap_ff;
      native_in    = native_ff;
      wthr_in      = wthr_ff;
      mthr_in      = mthr_ff;
      func_in      = func_ff;
      iscale_in    = iscale_ff;
      oscale_in    = oscale_ff;
      v_in         = v_ff;
      qlo_in       = qlo_ff;
      alu_cmd      = '0;

      if (csr_wr) begin
         if (csr_paddr[2] == tswr_pkg::REG_WRAP_THR) begin
            wthr_in = csr_pwdata;
         end else begin
            mthr_in = csr_pwdata;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_data.func;
               iscale_in = req_data.in_scale;
               oscale_in = req_data.out_scale;
               res_in    = '0;
               if (!known || err) begin
                  res_in.status = err;
                  state_in      = ST_RESP;
               end else if ((req_data.func == tswr_pkg::FUNC_STEP)
                         && (req_data.in_scale == 32'd0)) begin
                  v_in           = req_data.ts_value;
                  alu_cmd.start  = 1'b1;
                  alu_cmd.op     = tswr_pkg::ALU_MUL;
                  alu_cmd.opnd_a = {32'd0, req_data.ts_value - stamp_ff};
                  alu_cmd.opnd_b = req_data.out_scale;
                  state_in       = ST_MUL2;
               end else begin
                  alu_cmd.start  = 1'b1;
                  alu_cmd.op     = tswr_pkg::ALU_MUL;
                  alu_cmd.opnd_a = mul_a;
                  alu_cmd.opnd_b = mul_b;
                  state_in       = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            if (alu_rsp.done) begin
               alu_cmd.start  = 1'b1;
               alu_cmd.opnd_a = alu_rsp.value;
               if (func_ff == tswr_pkg::FUNC_SET_SCALE) begin
                  alu_cmd.op     = tswr_pkg::ALU_ADD;
                  alu_cmd.opnd_b = iscale_ff - 32'd1;
                  state_in       = ST_BIAS;
               end else if (func_ff == tswr_pkg::FUNC_READ) begin
                  alu_cmd.op     = tswr_pkg::ALU_ADD;
                  alu_cmd.opnd_b = native_ff - 32'd1;
                  state_in       = ST_BIAS;
               end else begin
                  alu_cmd.op     = tswr_pkg::ALU_DIV;
                  alu_cmd.opnd_b = divisor1;
                  state_in       = ST_DIV1;
               end
            end
         end
         ST_BIAS: begin
            if (alu_rsp.done) begin
               alu_cmd.start  = 1'b1;
               alu_cmd.op     = tswr_pkg::ALU_DIV;
               alu_cmd.opnd_a = alu_rsp.value;
               alu_cmd.opnd_b = divisor1;
               state_in       = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (alu_rsp.done) begin
               if (func_ff == tswr_pkg::FUNC_STEP) begin
                  v_in           = alu_rsp.value[31:0];
                  alu_cmd.start  = 1'b1;
                  alu_cmd.op     = tswr_pkg::ALU_MUL;
                  alu_cmd.opnd_a = {32'd0, alu_rsp.value[31:0] - stamp_ff};
                  alu_cmd.opnd_b = oscale_ff;
                  state_in       = ST_MUL2;
               end else if (func_ff == tswr_pkg::FUNC_READ) begin
                  res_in.result_value = alu_rsp.value[31:0];
                  state_in            = ST_RESP;
               end else begin
                  qlo_in         = alu_rsp.value[31:0];
                  alu_cmd.start  = 1'b1;
                  alu_cmd.op     = tswr_pkg::ALU_DIV;
                  alu_cmd.opnd_a = {32'd0, alu_rsp.value[63:32]};
                  alu_cmd.opnd_b = (func_ff == tswr_pkg::FUNC_RESCALE) ? oscale_ff : native_ff;
                  state_in       = ST_MOD;
               end
            end
         end
         ST_MUL2: begin
            if (alu_rsp.done) begin
               alu_cmd.start  = 1'b1;
               alu_cmd.op     = tswr_pkg::ALU_DIV;
               alu_cmd.opnd_a = alu_rsp.value;
               alu_cmd.opnd_b = native_ff;
               state_in       = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (alu_rsp.done) begin
               if (take) begin
                  stamp_in            = v_ff;
                  res_in.result_value = alu_rsp.value[31:0];
                  res_in.accepted     = 1'b1;
                  if (v_ff < stamp_ff) begin
                     wrap_in = wrap_next;
                  end
               end
               state_in = ST_RESP;
            end
         end
         ST_MOD: begin
            if (alu_rsp.done) begin
               wrap_in  = alu_rsp.rem;
               stamp_in = qlo_ff;
               if (func_ff == tswr_pkg::FUNC_RESCALE) begin
                  native_in = oscale_ff;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         stamp_ff     <= 32'd0;
         wrap_ff      <= 32'd0;
         native_ff    <= tswr_pkg::NATIVE_RESET;
         wthr_ff      <= tswr_pkg::THR_RESET;
         mthr_ff      <= tswr_pkg::THR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stamp_ff     <= stamp_in;
         wrap_ff      <= wrap_in;
         native_ff    <= native_in;
         wthr_ff      <= wthr_in;
         mthr_ff      <= mthr_in;
      end
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      func_ff     <= func_in;
      iscale_ff   <= iscale_in;
      oscale_ff   <= oscale_in;
      v_ff        <= v_in;
      qlo_ff      <= qlo_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == tswr_pkg::REG_WRAP_THR) ? wthr_ff : mthr_ff;

endmodule

FILE: rtl/tswr_chk.sv
module tswr_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input tswr_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input tswr_pkg::rsp_payload_type rsp_data,
   input logic                      csr_psel,
   input logic                      csr_penable,
   input logic                      csr_pwrite,
   input logic [2:0]                csr_paddr,
   input logic [31:0]               csr_pwdata,
   input logic [31:0]               csr_prdata,
   input logic                      csr_pready
);

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("not idle after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

   a_accept_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.accepted && rsp_data.status))
      else $error("beat both accepted and refused");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready)
      ##1 (csr_paddr[2] == $past(csr_paddr[2])) |-> (csr_prdata == $past(csr_pwdata)))
      else $error("register readback mismatch");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

bind timestamp_wrap_extend_rescale_top tswr_chk u_tswr_chk (.*);

FILE: sim/timestamp_wrap_extend_rescale_top_tb.sv
`timescale 1ns / 100ps

module timestamp_wrap_extend_rescale_top_tb;

   localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned DRAIN_CYCLES  = 300;
   localparam int unsigned HOLD_CYCLES   = 600;

   class stamp_clock_scoreboard;
      tswr_pkg::rsp_payload_type due_results[$];
      logic [31:0]               wrap_thr;
      logic [31:0]               misorder_thr;
      logic [31:0]               stamp;
      logic [31:0]               wraps;
      logic [31:0]               native;
      int                        errors;

      function new();
         wrap_thr     = tswr_pkg::THR_RESET;
         misorder_thr = tswr_pkg::THR_RESET;
         stamp        = '0;
         wraps        = '0;
         native       = tswr_pkg::NATIVE_RESET;
         errors       = 0;
      endfunction

      function void set_reg(logic idx, logic [31:0] val);
         if (idx == tswr_pkg::REG_WRAP_THR) begin
            wrap_thr = val;
         end else begin
            misorder_thr = val;
         end
      endfunction

      function void load_quotient(logic [63:0] q);
         wraps = q[63:32] % native;
         stamp = q[31:0];
      endfunction

      function tswr_pkg::rsp_payload_type predict_step(tswr_pkg::req_payload_type q);
         tswr_pkg::rsp_payload_type r;
         logic [31:0]               v;
         logic [31:0]               d;
         logic [63:0]               quot;
         logic [63:0]               scaled;
         logic                      take;
         r    = '0;
         take = 1'b0;
         if (q.func <= tswr_pkg::FUNC_READ && native == 0) begin
            r.status = 1'b1;
         end else begin
            case (q.func)
               tswr_pkg::FUNC_STEP: begin
                  v = q.ts_value;
                  if (q.in_scale != 0) begin
                     quot = (64'(q.ts_value) * 64'(native)) / 64'(q.in_scale);
                     v    = quot[31:0];
                  end
                  d      = v - stamp;
                  scaled = (64'(d) * 64'(q.out_scale)) / 64'(native);
                  if (v < stamp) begin
                     if (d < wrap_thr) begin
                        wraps = wraps + 32'd1;
                        if (wraps >= native) wraps = '0;
                        take = 1'b1;
                     end
                  end else if (d < misorder_thr) begin
                     take = 1'b1;
                  end
                  if (take) begin
                     stamp          = v;
                     r.accepted     = 1'b1;
                     r.result_value = scaled[31:0];
                  end
               end
               tswr_pkg::FUNC_SET_SCALE: begin
                  if (q.in_scale == 0) begin
                     r.status = 1'b1;
                  end else begin
                     quot = (64'(q.ts_value) * 64'(native) + 64'(q.in_scale - 32'd1))
                            / 64'(q.in_scale);
                     load_quotient(quot);
                  end
               end
               tswr_pkg::FUNC_RESCALE: begin
                  if (q.out_scale == 0) begin
                     r.status = 1'b1;
                  end else begin
                     scaled = {wraps, stamp} * 64'(q.out_scale);
                     quot   = scaled / 64'(native);
                     native = q.out_scale;
                     load_quotient(quot);
                  end
               end
               tswr_pkg::FUNC_SET_CLOCK: begin
                  if (q.in_scale == 0) begin
                     r.status = 1'b1;
                  end else begin
                     scaled = {q.src_wrap, q.ts_value} * 64'(native);
                     load_quotient(scaled / 64'(q.in_scale));
                  end
               end
               tswr_pkg::FUNC_READ: begin
                  quot = (64'(stamp) * 64'(q.out_scale) + 64'(native - 32'd1)) / 64'(native);
                  r.result_value = quot[31:0];
               end
               default: begin
               end
            endcase
         end
         return r;
      endfunction

      function void note_request(tswr_pkg::req_payload_type q);
         due_results.push_back(predict_step(q));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(tswr_pkg::rsp_payload_type r);
         tswr_pkg::rsp_payload_type want;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, r);
            errors++;
         end else begin
            want = due_results.pop_front();
            compare_field("result_value", want.result_value, r.result_value);
            compare_field("accepted", 32'(want.accepted), 32'(r.accepted));
            compare_field("status", 32'(want.status), 32'(r.status));
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   tswr_pkg::req_payload_type req_data;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   tswr_pkg::rsp_payload_type rsp_data;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [2:0]                csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   stamp_clock_scoreboard sb;
   logic                  quiet;
   int unsigned           results_seen = 0;
   int unsigned           idle_cycles  = 0;
   int unsigned           hold_left    = 0;
   logic                  hold_done    = 1'b0;

   timestamp_wrap_extend_rescale_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 150) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 13);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
            results_seen <= results_seen + 1;
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no beat moved for %0d cycles", $time, idle_cycles);
            $display("FAILED: results differ");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic logic [31:0] pick_scale();
      logic [31:0] s;
      case ($urandom_range(0, 9))
         0:       s = 32'd1;
         1:       s = 32'd1000;
         2:       s = 32'd90000;
         3:       s = 32'd44100;
         4:       s = 32'd1_000_000;
         5:       s = 32'hFFFF_FFFF;
         6:       s = $urandom_range(2, 16);
         7, 8:    s = $urandom;
         default: s = 32'd0;
      endcase
      return s;
   endfunction

   function automatic tswr_pkg::req_payload_type make_req(logic [2:0] f, logic [31:0] ts,
                                                          logic [31:0] sw, logic [31:0] isc,
                                                          logic [31:0] osc);
      tswr_pkg::req_payload_type p;
      p.func      = f;
      p.ts_value  = ts;
      p.src_wrap  = sw;
      p.in_scale  = isc;
      p.out_scale = osc;
      return p;
   endfunction

   // half steps, most near the current stamp or a limit, so that accepts, wraps and rejects all show up
   function automatic tswr_pkg::req_payload_type next_random_request();
      tswr_pkg::req_payload_type p;
      int unsigned               pick;
      int unsigned               kind;
      logic [31:0]               delta;
      p.func      = tswr_pkg::FUNC_STEP;
      p.ts_value  = $urandom;
      p.src_wrap  = $urandom;
      p.in_scale  = $urandom;
      p.out_scale = $urandom;
      pick        = $urandom_range(0, 99);
      kind        = $urandom_range(0, 9);
      if (pick < 50) begin
         case (kind)
            0, 1, 2, 3: delta = $urandom_range(0, 5000);
            4:          delta = $urandom_range(0, 32'h7FFF_FFFF);
            5:          delta = sb.misorder_thr + $urandom_range(0, 2) - 32'd1;
            6:          delta = sb.wrap_thr + $urandom_range(0, 2) - 32'd1;
            7:          delta = 32'd0 - 32'($urandom_range(1, 5000));
            default:    delta = $urandom;
         endcase
         p.ts_value = sb.stamp + delta;
         kind       = $urandom_range(0, 9);
         if (kind < 6) begin
            p.in_scale = '0;
         end else if (kind < 9) begin
            p.in_scale = sb.native;
         end
         p.out_scale = pick_scale();
      end else if (pick < 65) begin
         p.func      = tswr_pkg::FUNC_READ;
         p.out_scale = pick_scale();
      end else if (pick < 73) begin
         p.func      = tswr_pkg::FUNC_RESCALE;
         p.out_scale = pick_scale();
      end else if (pick < 82) begin
         p.func     = tswr_pkg::FUNC_SET_SCALE;
         p.in_scale = pick_scale();
      end else if (pick < 91) begin
         p.func     = tswr_pkg::FUNC_SET_CLOCK;
         p.in_scale = pick_scale();
         if (kind < 7) p.src_wrap = $urandom_range(0, 100);
      end else begin
         p.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
      end
      return p;
   endfunction

   task automatic send_item(tswr_pkg::req_payload_type p);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      sb.note_request(p);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(logic [31:0] wthr, logic [31:0] mthr, int unsigned n,
                            logic no_gaps);
      write_csr(tswr_pkg::REG_WRAP_THR, wthr);
      write_csr(tswr_pkg::REG_MISORDER_THR, mthr);
      quiet = no_gaps;
      repeat (n) send_item(next_random_request());
      quiet = 1'b0;
      settle();
   endtask

   initial begin
      sb           = new();
      reset        = 1'b1;
      quiet        = 1'b0;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, wraps, zero divisors, unused codes
      send_item(make_req(tswr_pkg::FUNC_READ, '0, '0, '0, 32'hFFFF_FFFF));
      send_item(make_req(tswr_pkg::FUNC_STEP, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF));
      send_item(make_req(tswr_pkg::FUNC_STEP, 32'h7FFF_FFFF, '0, '0, 32'd1));
      send_item(make_req(tswr_pkg::FUNC_STEP, 32'hFFFF_FFFE, '0, '0, 32'hFFFF_FFFF));
      send_item(make_req(tswr_pkg::FUNC_STEP, 32'd5, '0, '0, 32'd1000));
      send_item(make_req(tswr_pkg::FUNC_RESCALE, '1, '1, '1, '0));
      send_item(make_req(tswr_pkg::FUNC_SET_SCALE, '1, '1, '0, '1));
      send_item(make_req(tswr_pkg::FUNC_SET_CLOCK, '1, '1, '0, '1));
      send_item(make_req(tswr_pkg::FUNC_RESCALE, '0, '0, '0, 32'd90000));
      send_item(make_req(tswr_pkg::FUNC_SET_CLOCK, 32'hFFFF_FFF0, 32'd3, 32'd90000, '0));
      send_item(make_req(tswr_pkg::FUNC_STEP, 32'h10, '0, '0, 32'd1000));
      send_item(make_req(tswr_pkg::FUNC_READ, '0, '0, '0, 32'd1000));
      send_item(make_req(tswr_pkg::FUNC_READ, '1, '1, '1, '0));
      send_item(make_req(tswr_pkg::FUNC_STEP, '1, '0, '1, '1));
      send_item(make_req(tswr_pkg::FUNC_SET_SCALE, '1, '0, 32'd1, '0));
      send_item(make_req(tswr_pkg::FUNC_SET_SCALE, '1, '0, '1, '0));
      send_item(make_req(tswr_pkg::FUNC_SET_CLOCK, '1, '1, 32'd1, '0));
      send_item(make_req(tswr_pkg::FUNC_RESCALE, '0, '0, '0, '1));
      send_item(make_req(tswr_pkg::FUNC_READ, '0, '0, '0, '1));
      send_item(make_req(FUNC_UNUSED_LO, '1, '1, '1, '1));
      send_item(make_req(FUNC_UNUSED_LO + 3'd1, '0, '0, '0, '0));
      send_item(make_req(FUNC_UNUSED_HI, '1, '1, '1, '1));
      send_item(make_req(tswr_pkg::FUNC_RESCALE, '0, '0, '0, 32'd1));
      send_item(make_req(tswr_pkg::FUNC_STEP, '0, '0, '0, '1));
      settle();

      run_phase(tswr_pkg::THR_RESET, tswr_pkg::THR_RESET, 300, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 280, 1'b1);
      run_phase(32'h0000_0000, 32'hFFFF_FFFF, 250, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'h0000_0000, 250, 1'b0);
      run_phase($urandom, $urandom, 250, 1'b0);
      run_phase(32'h0000_0000, 32'h0000_0000, 70, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.due_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/tswr_pkg.sv
rtl/tswr_alu.sv
rtl/timestamp_wrap_extend_rescale_top.sv
rtl/tswr_chk.sv
sim/timestamp_wrap_extend_rescale_top_tb.sv
